### rtl/stasm_pkg.sv
// Shared types and constants for the sparse triplet add/subtract merge block.
package stasm_pkg;

    // Field widths
    localparam int ROW_W     = 10;
    localparam int COL_W     = 10;
    localparam int VAL_W     = 16;
    localparam int OUT_VAL_W = VAL_W + 1;
    localparam int ENTRY_W   = ROW_W + COL_W + VAL_W;
    localparam int OP_W      = 2;

    // Stream packing (whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Input opcodes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_START       = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_MARK
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic step;
        logic emit_empty;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic both_empty;
        logic step_last;
    } status_t;

endpackage

### rtl/stasm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stasm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/stasm_ctrl.sv
// Controller state machine: load sequencing, merge stepping, empty marker.
module stasm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            op,
    input  stasm_pkg::status_t    status,
    output stasm_pkg::cmd_t       cmd
);

    stasm_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stasm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            stasm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (op)
                        stasm_pkg::OP_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        stasm_pkg::OP_LOAD_SECOND: cmd.load_second = 1'b1;
                        stasm_pkg::OP_START: begin
                            state_next = status.both_empty ? stasm_pkg::ST_MARK
                                                           : stasm_pkg::ST_MERGE;
                        end
                        default: ;
                    endcase
                end
            end
            stasm_pkg::ST_MERGE: begin
                // one result per cycle while the output register has room
                if (status.out_free) begin
                    cmd.step = 1'b1;
                    if (status.step_last) begin
                        state_next = stasm_pkg::ST_IDLE;
                    end
                end
            end
            stasm_pkg::ST_MARK: begin
                if (status.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = stasm_pkg::ST_IDLE;
                end
            end
            default: state_next = stasm_pkg::ST_IDLE;
        endcase
    end

endmodule

### rtl/stasm_dp.sv
// Datapath: element stores, counts, merge pointers, compare/add and output register.
module stasm_dp #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic [stasm_pkg::ENTRY_W-1:0]      in_entry,
    input  stasm_pkg::cmd_t                    cmd,
    output stasm_pkg::status_t                 status,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stasm_pkg::ROW_W-1:0]        out_row,
    output logic [stasm_pkg::COL_W-1:0]        out_col,
    output logic [stasm_pkg::OUT_VAL_W-1:0]    out_value,
    output logic                               entry_valid,
    output logic                               last_item
);

    localparam int RW = stasm_pkg::ROW_W;
    localparam int KW = stasm_pkg::COL_W;
    localparam int OW = stasm_pkg::OUT_VAL_W;
    localparam int EW = stasm_pkg::ENTRY_W;

    logic          sub_mode_reg;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic          m_valid_reg, m_valid_next;
    logic [RW-1:0] row_reg;
    logic [KW-1:0] col_reg;
    logic [OW-1:0] val_reg;
    logic          ev_reg;
    logic          last_reg;

    logic [EW-1:0] ent_a, ent_b;
    logic          wr_a, wr_b;
    logic          a_av, b_av, a_lt, b_lt, take_a, take_b;
    logic [RW-1:0] a_row, b_row;
    logic [KW-1:0] a_col, b_col;
    logic [OW-1:0] a_ext, b_ext, res_val;
    logic [CW-1:0] idx_a_adv, idx_b_adv;
    logic          out_free, step_last;

    // Subtract-mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            sub_mode_reg <= cfg_wr_data;
        end
    end

    // Store writes, ignored when the store is full
    assign wr_a = cmd.load_first  && (cnt_a_reg != CW'(DEPTH));
    assign wr_b = cmd.load_second && (cnt_b_reg != CW'(DEPTH));

    stasm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_first_store (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[AW-1:0]),
        .wr_data (in_entry),
        .rd_addr (idx_a_next[AW-1:0]),
        .rd_data (ent_a)
    );

    stasm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_second_store (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[AW-1:0]),
        .wr_data (in_entry),
        .rd_addr (idx_b_next[AW-1:0]),
        .rd_data (ent_b)
    );

    // Entry fields: row lowest, then column, then value
    assign a_row = ent_a[RW-1:0];
    assign a_col = ent_a[RW+KW-1:RW];
    assign a_ext = {ent_a[EW-1], ent_a[EW-1:RW+KW]};
    assign b_row = ent_b[RW-1:0];
    assign b_col = ent_b[RW+KW-1:RW];
    assign b_ext = {ent_b[EW-1], ent_b[EW-1:RW+KW]};

    // Merge decision in row-major order
    always_comb begin
        a_av   = idx_a_reg < cnt_a_reg;
        b_av   = idx_b_reg < cnt_b_reg;
        a_lt   = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));
        b_lt   = (b_row < a_row) || ((b_row == a_row) && (b_col < a_col));
        take_a = a_av && (!b_av || a_lt);
        take_b = !take_a && b_av && (!a_av || b_lt);
        if (take_a) begin
            res_val = a_ext;
        end else if (take_b) begin
            res_val = sub_mode_reg ? (OW'(0) - b_ext) : b_ext;
        end else begin
            res_val = sub_mode_reg ? (a_ext - b_ext) : (a_ext + b_ext);
        end
        idx_a_adv = idx_a_reg + CW'(!take_b);
        idx_b_adv = idx_b_reg + CW'(!take_a);
        step_last = (idx_a_adv >= cnt_a_reg) && (idx_b_adv >= cnt_b_reg);
    end

    // Pointer and count updates
    always_comb begin
        idx_a_next = idx_a_reg;
        idx_b_next = idx_b_reg;
        cnt_a_next = cnt_a_reg + CW'(wr_a);
        cnt_b_next = cnt_b_reg + CW'(wr_b);
        if (cmd.step) begin
            if (step_last) begin
                idx_a_next = '0;
                idx_b_next = '0;
                cnt_a_next = '0;
                cnt_b_next = '0;
            end else begin
                idx_a_next = idx_a_adv;
                idx_b_next = idx_b_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
        end
    end

    // Output register
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (cmd.step || cmd.emit_empty) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            row_reg  <= take_b ? b_row : a_row;
            col_reg  <= take_b ? b_col : a_col;
            val_reg  <= res_val;
            ev_reg   <= 1'b1;
            last_reg <= step_last;
        end else if (cmd.emit_empty) begin
            row_reg  <= '0;
            col_reg  <= '0;
            val_reg  <= '0;
            ev_reg   <= 1'b0;
            last_reg <= 1'b1;
        end
    end

    assign status.out_free   = out_free;
    assign status.both_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign status.step_last  = step_last;

    assign m_tvalid    = m_valid_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign out_value   = val_reg;
    assign entry_valid = ev_reg;
    assign last_item   = last_reg;

endmodule

### rtl/sparse_triplet_add_subtract_merge_top.sv
// Sparse triplet merge: two element stores merged in row-major order, add or subtract.
// Load transactions complete immediately when accepted (no result).
// A start transaction emits N merged results from registered store reads, one per cycle
// unless the output stalls; N is at most the sum of both counts, one marker if both are empty.
// No new input is taken until the last result of a merge is in the output register.
// aresetn (synchronous, active low) clears counts, mode, state and output valid.
module sparse_triplet_add_subtract_merge_top #(
    parameter int DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: subtract_mode
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stasm_pkg::S_TDATA_W-1:0]    s_tdata,  // row_index, col_index, elem_value
    input  logic [stasm_pkg::OP_W-1:0]         s_tuser,  // op
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stasm_pkg::M_TDATA_W-1:0]    m_tdata,  // out_row, out_col, out_value
    output logic                               m_tuser,  // entry_valid
    output logic                               m_tlast   // last_item
);

    localparam int EW = stasm_pkg::ENTRY_W;
    localparam int RW = stasm_pkg::ROW_W;
    localparam int KW = stasm_pkg::COL_W;
    localparam int OW = stasm_pkg::OUT_VAL_W;

    stasm_pkg::cmd_t    cmd;
    stasm_pkg::status_t status;
    logic [RW-1:0]      out_row;
    logic [KW-1:0]      out_col;
    logic [OW-1:0]      out_value;

    stasm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    stasm_dp #(.DEPTH(DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_entry    (s_tdata[EW-1:0]),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .entry_valid (m_tuser),
        .last_item   (m_tlast)
    );

    // Pack result fields, zero fill to whole bytes
    assign m_tdata = {{(stasm_pkg::M_TDATA_W - RW - KW - OW){1'b0}}, out_value, out_col, out_row};

endmodule

### sim/tb_top.sv
// Self-checking testbench for the sparse triplet add/subtract merge block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_W     = stasm_pkg::ROW_W;
    localparam int COL_W     = stasm_pkg::COL_W;
    localparam int VAL_W     = stasm_pkg::VAL_W;
    localparam int OUT_VAL_W = stasm_pkg::OUT_VAL_W;
    localparam int ENTRY_W   = stasm_pkg::ENTRY_W;
    localparam int OP_W      = stasm_pkg::OP_W;
    localparam int S_TDATA_W = stasm_pkg::S_TDATA_W;
    localparam int M_TDATA_W = stasm_pkg::M_TDATA_W;

    localparam int STORE_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_LIST      = 36;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One stored triplet of either matrix
    typedef struct {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } triplet_t;

    // One merged result as the block should emit it
    typedef struct {
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
        logic signed [OUT_VAL_W-1:0] value;
        logic                        entry_valid;
        logic                        last;
    } merged_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Predictor state: both element lists, their counts and the mode
    triplet_t first_elems [STORE_DEPTH];
    triplet_t second_elems [STORE_DEPTH];
    int       first_count = 0;
    int       second_count = 0;
    bit       subtract_on = 1'b0;

    merged_t  merged_queue [$];
    int       mismatch_count = 0;
    int       items_sent = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       recv_hold = 0;

    sparse_triplet_add_subtract_merge_top #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Row-major ordering of two positions
    function automatic bit precedes(triplet_t a, triplet_t b);
        return (a.row < b.row) || (a.row == b.row && a.col < b.col);
    endfunction

    // Merge both lists into expected results, then clear the counts
    function automatic void merge_lists();
        int      i;
        int      j;
        bit      have;
        merged_t held;
        merged_t cur;
        logic signed [OUT_VAL_W-1:0] va;
        logic signed [OUT_VAL_W-1:0] vb;
        i = 0;
        j = 0;
        have = 1'b0;
        if (first_count == 0 && second_count == 0) begin
            merged_queue.push_back('{row: '0, col: '0, value: '0, entry_valid: 1'b0,
                                     last: 1'b1});
            return;
        end
        while (i < first_count || j < second_count) begin
            if (i < first_count && (j >= second_count ||
                                    precedes(first_elems[i], second_elems[j]))) begin
                va = first_elems[i].value;
                cur = '{first_elems[i].row, first_elems[i].col, va, 1'b1, 1'b0};
                i++;
            end else if (j < second_count && (i >= first_count ||
                                              precedes(second_elems[j], first_elems[i]))) begin
                vb = second_elems[j].value;
                cur = '{second_elems[j].row, second_elems[j].col,
                        subtract_on ? -vb : vb, 1'b1, 1'b0};
                j++;
            end else begin
                va = first_elems[i].value;
                vb = second_elems[j].value;
                cur = '{first_elems[i].row, first_elems[i].col,
                        subtract_on ? va - vb : va + vb, 1'b1, 1'b0};
                i++;
                j++;
            end
            if (have) merged_queue.push_back(held);
            held = cur;
            have = 1'b1;
        end
        held.last = 1'b1;
        merged_queue.push_back(held);
        first_count = 0;
        second_count = 0;
    endfunction

    // Update the predictor with one accepted input transaction
    function automatic void track_input(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                        logic [COL_W-1:0] col,
                                        logic signed [VAL_W-1:0] val);
        case (op)
            stasm_pkg::OP_LOAD_FIRST: begin
                if (first_count < STORE_DEPTH) begin
                    first_elems[first_count] = '{row, col, val};
                    first_count++;
                end
            end
            stasm_pkg::OP_LOAD_SECOND: begin
                if (second_count < STORE_DEPTH) begin
                    second_elems[second_count] = '{row, col, val};
                    second_count++;
                end
            end
            stasm_pkg::OP_START: merge_lists();
            default: ;
        endcase
    endfunction

    // Offer one transaction, with a random idle gap ahead of it; valid stays high after
    task automatic send_item(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col, logic signed [VAL_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < 20 && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - ENTRY_W){1'b0}}, val, col, row};
        do @(posedge aclk); while (!s_tready);
        track_input(op, row, col, val);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        s_tvalid <= 1'b0;
        while (merged_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(bit mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        subtract_on = mode;
    endtask

    // Two lists over overlapping positions, sorted unless scrambled, loads interleaved, then a start
    task automatic send_sequence(int n_first, int n_second, bit scramble);
        int unsigned pos_a [MAX_LIST];
        int unsigned pos_b [MAX_LIST];
        int unsigned base;
        int unsigned tmp;
        int i;
        int j;
        int k;
        if ($urandom_range(5) == 0) base = $urandom_range(1048575 - 110, 1048455);
        else base = $urandom_range(1048575 - 110);
        for (k = 0; k < MAX_LIST; k++) begin
            pos_a[k] = (k == 0) ? base + $urandom_range(2) : pos_a[k-1] + $urandom_range(1, 3);
            pos_b[k] = (k == 0) ? base + $urandom_range(2) : pos_b[k-1] + $urandom_range(1, 3);
        end
        // broken ordering in the first list
        if (scramble && n_first > 1) begin
            tmp = pos_a[0];
            pos_a[0] = pos_a[n_first-1];
            pos_a[n_first-1] = tmp;
        end
        i = 0;
        j = 0;
        while (i < n_first || j < n_second) begin
            if ($urandom_range(19) == 0)
                send_item(OP_UNUSED, ROW_W'($urandom_range(1023)),
                          COL_W'($urandom_range(1023)), VAL_W'($urandom_range(65535)));
            if (i < n_first && (j >= n_second || $urandom_range(1))) begin
                send_item(stasm_pkg::OP_LOAD_FIRST, ROW_W'(pos_a[i] >> 10),
                          COL_W'(pos_a[i] & 1023), VAL_W'($urandom_range(65535)));
                i++;
            end else begin
                send_item(stasm_pkg::OP_LOAD_SECOND, ROW_W'(pos_b[j] >> 10),
                          COL_W'(pos_b[j] & 1023), VAL_W'($urandom_range(65535)));
                j++;
            end
        end
        send_item(stasm_pkg::OP_START, ROW_W'($urandom_range(1023)),
                  COL_W'($urandom_range(1023)), VAL_W'($urandom_range(65535)));
    endtask

    // Result side: check each accepted transaction, then decide the next stall
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (merged_queue.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d tdata %h user %b last %b",
                         $time, m_tdata[9:0], m_tdata[19:10], m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                merged_t want;
                want = merged_queue.pop_front();
                if (m_tdata[9:0] !== want.row || m_tdata[19:10] !== want.col ||
                    m_tdata[36:20] !== want.value || m_tuser !== want.entry_valid ||
                    m_tlast !== want.last) begin
                    $display("%0t: expected row %0d col %0d value %0d valid %b last %b",
                             $time, want.row, want.col, want.value, want.entry_valid,
                             want.last);
                    $display("%0t: actual   row %0d col %0d value %0d valid %b last %b",
                             $time, m_tdata[9:0], m_tdata[19:10],
                             $signed(m_tdata[36:20]), m_tuser, m_tlast);
                    mismatch_count++;
                end
            end
        end
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both lists empty, plus an unused opcode that must be ignored
    task automatic test_empty_lists();
        send_item(OP_UNUSED, 10'h3FF, 10'h3FF, 16'hFFFF);
        send_item(stasm_pkg::OP_START, 10'd0, 10'd0, 16'd0);
        drain();
    endtask

    // Add mode: field extremes, collisions, a second-only entry, a zero sum
    task automatic test_add_extremes();
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd0, 10'd0, VAL_W'(-32768));
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd0, 10'd1023, VAL_W'(32767));
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd5, 10'd5, VAL_W'(100));
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd1023, 10'd1023, VAL_W'(-1));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd0, 10'd0, VAL_W'(-32768));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd0, 10'd1023, VAL_W'(32767));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd3, 10'd0, VAL_W'(7));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd1023, 10'd1023, VAL_W'(1));
        send_item(stasm_pkg::OP_START, 10'd0, 10'd0, 16'd0);
        drain();
    endtask

    // Subtract mode: negated second-only entries, zero difference, empty lists again
    task automatic test_subtract_extremes();
        write_mode(1'b1);
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd1, 10'd1, VAL_W'(-32768));
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd2, 10'd2, VAL_W'(5));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd1, 10'd0, VAL_W'(-32768));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd1, 10'd1, VAL_W'(32767));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd2, 10'd2, VAL_W'(5));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd1023, 10'd1023, VAL_W'(32767));
        send_item(stasm_pkg::OP_START, 10'd0, 10'd0, 16'd0);
        send_item(stasm_pkg::OP_START, 10'd0, 10'd0, 16'd0);
        drain();
    endtask

    // Lists out of order: the merge runs on regardless
    task automatic test_unsorted_lists();
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd9, 10'd9, VAL_W'(1));
        send_item(stasm_pkg::OP_LOAD_FIRST, 10'd2, 10'd2, VAL_W'(2));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd5, 10'd5, VAL_W'(3));
        send_item(stasm_pkg::OP_LOAD_SECOND, 10'd2, 10'd2, VAL_W'(4));
        send_item(stasm_pkg::OP_START, 10'd0, 10'd0, 16'd0);
        drain();
    endtask

    // Loads beyond a full store are dropped
    task automatic test_store_full();
        send_sequence(MAX_LIST - 2, MAX_LIST - 3, 1'b0);
        drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 400;
        send_sequence(30, 30, 1'b0);
        send_sequence(10, 10, 1'b0);
        drain();
    endtask

    // Random sequences under one idling mix and one mode
    task automatic test_random_phase(int idle_pct, int stall_pct, bit mode, int target);
        int stop_at;
        int n_first;
        int n_second;
        write_mode(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            n_first  = ($urandom_range(9) == 0) ? $urandom_range(MAX_LIST) : $urandom_range(8);
            n_second = ($urandom_range(9) == 0) ? $urandom_range(MAX_LIST) : $urandom_range(8);
            send_sequence(n_first, n_second, $urandom_range(9) == 0);
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_lists();
        test_add_extremes();
        test_subtract_extremes();
        test_unsorted_lists();
        test_store_full();
        test_backpressure();
        test_random_phase(0, 0, 1'b0, 15);
        test_random_phase(67, 0, 1'b1, 15);
        test_random_phase(0, 67, 1'b0, 15);
        test_random_phase(35, 35, 1'b1, 15);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/stasm_pkg.sv
rtl/stasm_ram.sv
rtl/stasm_ctrl.sv
rtl/stasm_dp.sv
rtl/sparse_triplet_add_subtract_merge_top.sv
sim/tb_top.sv
